### design/spqb_pkg.sv
// ============================================================================
// spqb_pkg
// Shared field widths and operation and status codes for the priority
// queue bank.
// ============================================================================
`default_nettype none

package spqb_pkg;

    // Port field widths.
    localparam int KIND_W   = 2;
    localparam int QSEL_W   = 3;
    localparam int PRIO_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [PRIO_W-1:0]   prio_t;

    // Operation codes.
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_POP    = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;

    // Result status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // A priority of zero is served as the best level.
    localparam prio_t PRIO_BEST = 2'd1;

endpackage

`default_nettype wire

### design/spqb_ram.sv
// ============================================================================
// spqb_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ============================================================================
`default_nettype none

module spqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/stable_priority_queue_bank.sv
// ============================================================================
// stable_priority_queue_bank
// Bank of bounded priority queues with insert, pop and remove-by-id.
// ============================================================================
// Each request beat addresses one queue. Entries sit in service order in one
// entry RAM, and the queue fill counts sit in a small count RAM whose entries
// read as zero until first written, so the block is usable right after reset
// with no clearing pass. One request is worked at a time, one entry per clock
// through the entry RAM: an insert walks back from the tail only as far as
// the new entry's place, a pop or a remove walks the whole queue, and an
// empty queue, a full queue or the unused kind code skips the walk. A new
// request is taken while the previous response still waits in the output
// register.
// ============================================================================
`default_nettype none

module stable_priority_queue_bank #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [spqb_pkg::KIND_W-1:0]   kind,
    input  wire logic [spqb_pkg::QSEL_W-1:0]   queue_select,
    input  wire logic [spqb_pkg::PRIO_W-1:0]   entry_priority,
    input  wire logic [spqb_pkg::ID_W-1:0]     entry_id,

    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [spqb_pkg::STATUS_W-1:0]      status,
    output logic [spqb_pkg::ID_W-1:0]          removed_id,
    output logic [spqb_pkg::COUNT_W-1:0]       entry_count,
    output logic                               queue_empty
);

    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = ID_BITS + spqb_pkg::PRIO_W;
    localparam int EAW = QW + SW;

    localparam logic [6:0]    NQ7       = 7'(NUM_QUEUES);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_INS0 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    spqb_pkg::kind_t              kind_reg, kind_next;
    logic [QW-1:0]                q_reg, q_next;
    spqb_pkg::prio_t              prio_reg, prio_next;
    logic [ID_BITS-1:0]           id_reg, id_next;
    logic [CW-1:0]                n_reg, n_next;
    logic [CW-1:0]                new_n_reg, new_n_next;
    logic [SW-1:0]                k_reg, k_next;
    logic                         found_reg, found_next;
    spqb_pkg::status_t            status_reg, status_next;
    logic [spqb_pkg::ID_W-1:0]    removed_reg, removed_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    spqb_pkg::status_t            rsp_status_reg, rsp_status_next;
    logic [spqb_pkg::ID_W-1:0]    rsp_id_reg, rsp_id_next;
    logic [spqb_pkg::COUNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic                         rsp_empty_reg, rsp_empty_next;

    logic [NUM_QUEUES-1:0]        cnt_valid_reg;

    logic                         req_fire;
    logic                         out_free;
    logic                         out_load;
    logic [6:0]                   q_wide;
    logic [QW-1:0]                q_in;
    spqb_pkg::prio_t              prio_in;
    logic [ID_BITS-1:0]           id_in;

    logic                         ent_we, ent_re;
    logic [EAW-1:0]               ent_waddr, ent_raddr;
    logic [EW-1:0]                ent_wdata, ent_rdata;
    logic [ID_BITS-1:0]           ent_rid;
    spqb_pkg::prio_t              ent_rprio;

    logic                         cnt_we;
    logic [CW-1:0]                cnt_rdata;
    logic [CW-1:0]                cnt_n;
    logic [CW-1:0]                cnt_last;

    logic [SW-1:0]                k_inc, k_dec;
    logic                         last_slot;
    logic                         hit;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // The queue number is reduced into range by repeated subtraction; the
    // select field is only three bits wide, so a few steps always suffice.
    always_comb
    begin
        q_wide = {4'd0, queue_select};
        for (int i = 0; i < 8; i++)
        begin
            if (q_wide >= NQ7)
            begin
                q_wide = q_wide - NQ7;
            end
        end
    end

    assign q_in    = q_wide[QW-1:0];
    assign prio_in = (entry_priority == '0) ? spqb_pkg::PRIO_BEST : entry_priority;
    assign id_in   = ID_BITS'(entry_id);

    assign ent_rid   = ent_rdata[ID_BITS-1:0];
    assign ent_rprio = ent_rdata[EW-1:ID_BITS];
    assign cnt_n     = cnt_valid_reg[q_reg] ? cnt_rdata : '0;
    assign cnt_last  = cnt_n - 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign k_dec     = k_reg - 1'b1;
    assign last_slot = (CW'(k_reg) == (n_reg - 1'b1));
    assign hit       = !found_reg &&
                       ((kind_reg == spqb_pkg::KIND_POP) || (ent_rid == id_reg));

    spqb_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** EAW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    spqb_ram #(
        .WIDTH (CW),
        .DEPTH (2 ** QW)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (q_reg),
        .wdata (new_n_reg),
        .re    (req_fire),
        .raddr (q_in),
        .rdata (cnt_rdata)
    );

    // Insert walks backward from the tail, moving each worse entry one slot
    // up until the new entry's place is found. Pop and remove walk forward
    // from the head and close the gap behind the matching entry.
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        q_next       = q_reg;
        prio_next    = prio_reg;
        id_next      = id_reg;
        n_next       = n_reg;
        new_n_next   = new_n_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        ent_we       = 1'b0;
        ent_waddr    = {q_reg, k_inc};
        ent_wdata    = ent_rdata;
        ent_re       = 1'b0;
        ent_raddr    = {q_reg, k_reg};
        cnt_we       = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next    = kind;
                    q_next       = q_in;
                    prio_next    = prio_in;
                    id_next      = id_in;
                    found_next   = 1'b0;
                    status_next  = spqb_pkg::ST_OK;
                    removed_next = '0;
                    state_next   = S_CNT;
                end
            end

            S_CNT:
            begin
                n_next     = cnt_n;
                new_n_next = cnt_n;
                state_next = S_FIN;
                case (kind_reg) inside
                    spqb_pkg::KIND_INSERT:
                    begin
                        if (cnt_n >= DEPTH_CNT)
                        begin
                            status_next = spqb_pkg::ST_FULL;
                        end
                        else if (cnt_n == '0)
                        begin
                            ent_we     = 1'b1;
                            ent_waddr  = {q_reg, {SW{1'b0}}};
                            ent_wdata  = {prio_reg, id_reg};
                            new_n_next = CW'(1);
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = {q_reg, cnt_last[SW-1:0]};
                            k_next     = cnt_last[SW-1:0];
                            new_n_next = cnt_n + 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    spqb_pkg::KIND_POP, spqb_pkg::KIND_REMOVE:
                    begin
                        if (cnt_n == '0)
                        begin
                            status_next = spqb_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = {q_reg, {SW{1'b0}}};
                            k_next     = '0;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_WALK:
            begin
                if (kind_reg == spqb_pkg::KIND_INSERT)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = {q_reg, k_inc};
                    if (ent_rprio <= prio_reg)
                    begin
                        ent_wdata  = {prio_reg, id_reg};
                        state_next = S_FIN;
                    end
                    else if (k_reg == '0)
                    begin
                        state_next = S_INS0;
                    end
                    else
                    begin
                        ent_re    = 1'b1;
                        ent_raddr = {q_reg, k_dec};
                        k_next    = k_dec;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = {q_reg, k_dec};
                    end
                    if (hit)
                    begin
                        found_next = 1'b1;
                        if (kind_reg == spqb_pkg::KIND_POP)
                        begin
                            removed_next = spqb_pkg::ID_W'(ent_rid);
                        end
                    end
                    if (last_slot)
                    begin
                        if (found_reg || hit)
                        begin
                            new_n_next = n_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = spqb_pkg::ST_NOT_FOUND;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ent_re    = 1'b1;
                        ent_raddr = {q_reg, k_inc};
                        k_next    = k_inc;
                    end
                end
            end

            S_INS0:
            begin
                ent_we     = 1'b1;
                ent_waddr  = {q_reg, {SW{1'b0}}};
                ent_wdata  = {prio_reg, id_reg};
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    cnt_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_empty_next  = rsp_empty_reg;
        if (out_load)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = status_reg;
            rsp_id_next     = removed_reg;
            rsp_count_next  = spqb_pkg::COUNT_W'(new_n_reg);
            rsp_empty_next  = (new_n_reg == '0);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cnt_we)
            begin
                cnt_valid_reg[q_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        q_reg          <= q_next;
        prio_reg       <= prio_next;
        id_reg         <= id_next;
        n_reg          <= n_next;
        new_n_reg      <= new_n_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        removed_reg    <= removed_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign removed_id  = rsp_id_reg;
    assign entry_count = rsp_count_reg;
    assign queue_empty = rsp_empty_reg;

    // A finished result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response register overwritten while stalled");

    // The walk index stays inside the occupied part of the queue.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CW'(k_reg) < n_reg))
        else $error("walk index beyond queue fill");

    // A count written back never exceeds the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (new_n_reg <= DEPTH_CNT))
        else $error("queue count beyond depth");

    // A full status only ever comes from an insert.
    a_full_is_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (status_reg == spqb_pkg::ST_FULL))
            |-> (kind_reg == spqb_pkg::KIND_INSERT))
        else $error("full status on a non-insert request");

endmodule

`default_nettype wire

### tb/stable_priority_queue_bank_test.sv
// ============================================================================
// stable_priority_queue_bank_test
// Self-checking bench for the priority queue bank.
// ============================================================================
// A short table of hand-picked requests comes first: empty queues after
// reset, every operation, priority zero, an absent id, the unused kind code
// and a queue driven to full. Then comes a long random run in phases. Each
// phase favors two queues and leans toward filling or draining them. Removes
// mostly name ids that are really queued. A local shadow of every queue
// predicts each response, and responses are matched in order. Both sides of
// the handshake pause at random.
// ============================================================================

module stable_priority_queue_bank_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int NUM_Q           = 8;
    localparam int DEPTH           = 16;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int DRAIN_CYCLES    = 30;
    localparam int QUIET_LIMIT     = 4000;

    // The fourth kind code has no meaning and must leave the queue alone.
    localparam spqb_pkg::kind_t KIND_UNUSED = 2'd3;

    typedef logic [spqb_pkg::QSEL_W-1:0] qsel_t;
    typedef logic [spqb_pkg::ID_W-1:0]   qid_t;

    typedef struct packed {
        spqb_pkg::status_t            status;
        qid_t                         removed_id;
        logic [spqb_pkg::COUNT_W-1:0] entry_count;
        logic                         queue_empty;
    } queue_result_t;

    typedef struct packed {
        spqb_pkg::kind_t kind;
        qsel_t           qsel;
        spqb_pkg::prio_t prio;
        qid_t            id;
        int              reps;
        bit              typed;
        queue_result_t   want;
    } plan_row_t;

    localparam int PLAN_ROWS = 15;

    // Repeated rows step both the id and the priority on each pass.
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{spqb_pkg::KIND_POP,    3'd0, 2'd1, 16'h0000, 1,  1'b1,
          '{spqb_pkg::ST_EMPTY, 16'h0, 5'd0, 1'b1}},
        '{spqb_pkg::KIND_REMOVE, 3'd7, 2'd2, 16'hFFFF, 1,  1'b1,
          '{spqb_pkg::ST_EMPTY, 16'h0, 5'd0, 1'b1}},
        '{KIND_UNUSED,           3'd3, 2'd3, 16'hA5A5, 1,  1'b1,
          '{spqb_pkg::ST_OK, 16'h0, 5'd0, 1'b1}},
        '{spqb_pkg::KIND_INSERT, 3'd1, 2'd3, 16'hFFFF, 1,  1'b0, '0},
        '{spqb_pkg::KIND_INSERT, 3'd1, 2'd1, 16'h0000, 1,  1'b0, '0},
        '{spqb_pkg::KIND_INSERT, 3'd1, 2'd0, 16'h1234, 1,  1'b0, '0},
        '{spqb_pkg::KIND_INSERT, 3'd1, 2'd2, 16'h5555, 1,  1'b0, '0},
        '{spqb_pkg::KIND_POP,    3'd1, 2'd1, 16'h0000, 1,  1'b0, '0},
        '{spqb_pkg::KIND_REMOVE, 3'd1, 2'd1, 16'h9999, 1,  1'b0, '0},
        '{spqb_pkg::KIND_REMOVE, 3'd1, 2'd1, 16'hFFFF, 1,  1'b0, '0},
        '{spqb_pkg::KIND_POP,    3'd1, 2'd1, 16'h0000, 1,  1'b0, '0},
        '{KIND_UNUSED,           3'd1, 2'd0, 16'h0000, 1,  1'b0, '0},
        '{spqb_pkg::KIND_INSERT, 3'd6, 2'd0, 16'hFF00, 16, 1'b0, '0},
        '{spqb_pkg::KIND_INSERT, 3'd6, 2'd1, 16'h0BAD, 1,  1'b1,
          '{spqb_pkg::ST_FULL, 16'h0, 5'd16, 1'b0}},
        '{spqb_pkg::KIND_POP,    3'd6, 2'd1, 16'h0000, 1,  1'b0, '0}
    };

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          req_valid      = 1'b0;
    logic                          req_stall;
    logic [spqb_pkg::KIND_W-1:0]   kind           = '0;
    logic [spqb_pkg::QSEL_W-1:0]   queue_select   = '0;
    logic [spqb_pkg::PRIO_W-1:0]   entry_priority = '0;
    logic [spqb_pkg::ID_W-1:0]     entry_id       = '0;
    logic                          rsp_valid;
    logic                          rsp_stall      = 1'b0;
    logic [spqb_pkg::STATUS_W-1:0] status;
    logic [spqb_pkg::ID_W-1:0]     removed_id;
    logic [spqb_pkg::COUNT_W-1:0]  entry_count;
    logic                          queue_empty;

    // Shadow copy of the bank, kept in service order per queue.
    qid_t            shadow_ids   [NUM_Q][DEPTH];
    spqb_pkg::prio_t shadow_prio  [NUM_Q][DEPTH];
    int              shadow_fill  [NUM_Q];

    queue_result_t pending_results [$];

    bit idle_on      = 1'b1;
    int errors       = 0;
    int requests_in  = 0;
    int results_seen = 0;
    int full_seen    = 0;
    int empty_seen   = 0;
    int absent_seen  = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    stable_priority_queue_bank dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .queue_select   (queue_select),
        .entry_priority (entry_priority),
        .entry_id       (entry_id),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .removed_id     (removed_id),
        .entry_count    (entry_count),
        .queue_empty    (queue_empty)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void drop_entry(int q, int pos);
        for (int k = pos; k + 1 < shadow_fill[q]; k++)
        begin
            shadow_ids[q][k]  = shadow_ids[q][k + 1];
            shadow_prio[q][k] = shadow_prio[q][k + 1];
        end
        shadow_fill[q]--;
    endfunction

    // Applies one request to the shadow bank and returns the response it earns.
    function automatic queue_result_t apply_request(spqb_pkg::kind_t k, qsel_t qs,
                                                    spqb_pkg::prio_t p, qid_t id);
        queue_result_t res;
        int q;
        int n;
        int pos;
        q   = int'(qs) % NUM_Q;
        n   = shadow_fill[q];
        res = '0;
        res.status = spqb_pkg::ST_OK;
        if (p == 2'd0)
        begin
            p = spqb_pkg::PRIO_BEST;
        end
        case (k)
            spqb_pkg::KIND_INSERT:
            begin
                if (n >= DEPTH)
                begin
                    res.status = spqb_pkg::ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < n && shadow_prio[q][pos] <= p)
                    begin
                        pos++;
                    end
                    for (int j = n; j > pos; j--)
                    begin
                        shadow_ids[q][j]  = shadow_ids[q][j - 1];
                        shadow_prio[q][j] = shadow_prio[q][j - 1];
                    end
                    shadow_ids[q][pos]  = id;
                    shadow_prio[q][pos] = p;
                    shadow_fill[q]      = n + 1;
                end
            end
            spqb_pkg::KIND_POP:
            begin
                if (n == 0)
                begin
                    res.status = spqb_pkg::ST_EMPTY;
                end
                else
                begin
                    res.removed_id = shadow_ids[q][0];
                    drop_entry(q, 0);
                end
            end
            spqb_pkg::KIND_REMOVE:
            begin
                if (n == 0)
                begin
                    res.status = spqb_pkg::ST_EMPTY;
                end
                else
                begin
                    pos = 0;
                    while (pos < n && shadow_ids[q][pos] != id)
                    begin
                        pos++;
                    end
                    if (pos >= n)
                    begin
                        res.status = spqb_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        drop_entry(q, pos);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = shadow_fill[q][spqb_pkg::COUNT_W-1:0];
        res.queue_empty = (shadow_fill[q] == 0);
        return res;
    endfunction

    // Presents one request beat, holds it through stalls and records the
    // response it should produce.
    task automatic send_request(spqb_pkg::kind_t k, qsel_t qs, spqb_pkg::prio_t p,
                                qid_t id, bit typed, queue_result_t want);
        int gap;
        queue_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        kind           <= k;
        queue_select   <= qs;
        entry_priority <= p;
        entry_id       <= id;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        predicted = apply_request(k, qs, p, id);
        pending_results.push_back(typed ? want : predicted);
        requests_in++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Response side: check accepted beats, then pick the next stall state.
    always @(posedge clk)
    begin : response_side
        queue_result_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: response beat with nothing expected, status %0h id %0h",
                         $time, status, removed_id);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("removed_id", 32'(want.removed_id), 32'(removed_id));
                check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                check_field("queue_empty", 32'(want.queue_empty), 32'(queue_empty));
                results_seen++;
                if (want.status == spqb_pkg::ST_FULL)
                begin
                    full_seen++;
                end
                if (want.status == spqb_pkg::ST_EMPTY)
                begin
                    empty_seen++;
                end
                if (want.status == spqb_pkg::ST_NOT_FOUND)
                begin
                    absent_seen++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall  <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Ends a run in which no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int roll;
        int fill;
        int insert_pct;
        qsel_t hot_a;
        qsel_t hot_b;
        qsel_t qs;
        spqb_pkg::kind_t k;
        spqb_pkg::prio_t p;
        qid_t id;

        foreach (shadow_fill[q])
        begin
            shadow_fill[q] = 0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            for (int r = 0; r < directed_plan[i].reps; r++)
            begin
                send_request(directed_plan[i].kind, directed_plan[i].qsel,
                             spqb_pkg::prio_t'(directed_plan[i].prio + r),
                             qid_t'(directed_plan[i].id + r),
                             directed_plan[i].typed, directed_plan[i].want);
            end
        end
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end

        // Each phase leans on two queues so they fill up or run dry, and
        // even phases favor inserts while odd ones favor removal.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_on    = (phase != 0);
            hot_a      = qsel_t'($urandom_range(0, NUM_Q - 1));
            hot_b      = qsel_t'($urandom_range(0, NUM_Q - 1));
            insert_pct = (phase % 2 == 0) ? 62 : 38;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    qs = hot_a;
                end
                else if (roll < 75)
                begin
                    qs = hot_b;
                end
                else
                begin
                    qs = qsel_t'($urandom_range(0, NUM_Q - 1));
                end
                p  = spqb_pkg::prio_t'($urandom_range(0, 3));
                id = ($urandom_range(0, 9) < 3) ? qid_t'($urandom_range(0, 7))
                                                : qid_t'($urandom_range(0, 65535));
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                begin
                    k = spqb_pkg::KIND_INSERT;
                end
                else if (roll < insert_pct + (95 - insert_pct) / 2)
                begin
                    k = spqb_pkg::KIND_POP;
                end
                else if (roll < 95)
                begin
                    k = spqb_pkg::KIND_REMOVE;
                    fill = shadow_fill[qs];
                    if (fill != 0 && $urandom_range(0, 3) != 0)
                    begin
                        id = shadow_ids[qs][$urandom_range(0, fill - 1)];
                    end
                end
                else
                begin
                    k = KIND_UNUSED;
                end
                send_request(k, qs, p, id, 1'b0, '0);
            end
            req_valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d queues and checked %0d responses.",
                 requests_in, NUM_Q, results_seen);
        $display("Responses included %0d full, %0d empty and %0d id-not-found cases.",
                 full_seen, empty_seen, absent_seen);
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
design/spqb_pkg.sv
design/spqb_ram.sv
design/stable_priority_queue_bank.sv
tb/stable_priority_queue_bank_test.sv
